[rtl/core/two_road_traffic_light_controller_macros.svh]
// Assertion macros for the traffic light controller.
// Both macros expect signals named clk and arst_n in the module that uses them.
`ifndef TWO_ROAD_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`define TWO_ROAD_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TRLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define TRLC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define TRLC_ASSERT(lbl, prop, msg)

`define TRLC_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

[rtl/core/trlc_pkg.sv]
package trlc_pkg;

	localparam int TICK_COUNT_WIDTH_DEF = 16;
	localparam int CFG_WIDTH            = 16;
	localparam int CFG_INDEX_WIDTH      = 2;
	localparam int COLOUR_WIDTH         = 12;
	localparam int LED_WIDTH            = 16;
	localparam int DIGIT_WIDTH          = 2;

	typedef enum logic [1:0] {
		PH_RED       = 2'd0,
		PH_RED_AMBER = 2'd1,
		PH_GREEN     = 2'd2,
		PH_AMBER     = 2'd3
	} phase_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_DISPLAY_SWITCH = 2'd0,
		CFG_PHASE          = 2'd1,
		CFG_WALK           = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_WIDTH-1:0] DISPLAY_SWITCH_RST = 16'd250;
	localparam logic [CFG_WIDTH-1:0] PHASE_TICKS_RST    = 16'd500;
	localparam logic [CFG_WIDTH-1:0] WALK_TICKS_RST     = 16'd1250;

	localparam logic [COLOUR_WIDTH-1:0] LAMP_RED   = 12'hF00;
	localparam logic [COLOUR_WIDTH-1:0] LAMP_AMBER = 12'hFF0;
	localparam logic [COLOUR_WIDTH-1:0] LAMP_GREEN = 12'h0F0;
	localparam logic [COLOUR_WIDTH-1:0] LAMP_OFF   = 12'hFFF;

	localparam logic [LED_WIDTH-1:0] LED_BOTH_RED   = 16'h8004;
	localparam logic [LED_WIDTH-1:0] LED_ONE_RA     = 16'hC004;
	localparam logic [LED_WIDTH-1:0] LED_ONE_GREEN  = 16'h2004;
	localparam logic [LED_WIDTH-1:0] LED_ONE_AMBER  = 16'h4004;
	localparam logic [LED_WIDTH-1:0] LED_TWO_RA     = 16'h8006;
	localparam logic [LED_WIDTH-1:0] LED_TWO_GREEN  = 16'h8001;
	localparam logic [LED_WIDTH-1:0] LED_TWO_AMBER  = 16'h8002;

	localparam logic [DIGIT_WIDTH-1:0] DIGIT_ONE = 2'd1;
	localparam logic [DIGIT_WIDTH-1:0] DIGIT_TWO = 2'd2;

	typedef struct packed {
		logic [LED_WIDTH-1:0]    led_word;
		logic [COLOUR_WIDTH-1:0] two_bottom;
		logic [COLOUR_WIDTH-1:0] two_middle;
		logic [COLOUR_WIDTH-1:0] two_top;
		logic [COLOUR_WIDTH-1:0] one_bottom;
		logic [COLOUR_WIDTH-1:0] one_middle;
		logic [COLOUR_WIDTH-1:0] one_top;
	} lamps_t;

endpackage

[rtl/core/trlc_lamp_decode.sv]
module trlc_lamp_decode (
	input  trlc_pkg::phase_t phase_one,
	input  trlc_pkg::phase_t phase_two,
	output trlc_pkg::lamps_t lamps
);
	import trlc_pkg::*;

	always_comb begin
		lamps.one_top    = (phase_one == PH_RED || phase_one == PH_RED_AMBER) ?
			LAMP_RED : LAMP_OFF;
		lamps.one_middle = (phase_one == PH_RED_AMBER || phase_one == PH_AMBER) ?
			LAMP_AMBER : LAMP_OFF;
		lamps.one_bottom = (phase_one == PH_GREEN) ? LAMP_GREEN : LAMP_OFF;
		lamps.two_top    = (phase_two == PH_RED || phase_two == PH_RED_AMBER) ?
			LAMP_RED : LAMP_OFF;
		lamps.two_middle = (phase_two == PH_RED_AMBER || phase_two == PH_AMBER) ?
			LAMP_AMBER : LAMP_OFF;
		lamps.two_bottom = (phase_two == PH_GREEN) ? LAMP_GREEN : LAMP_OFF;

		case (phase_one)
			PH_RED: begin
				case (phase_two)
					PH_RED:       lamps.led_word = LED_BOTH_RED;
					PH_RED_AMBER: lamps.led_word = LED_TWO_RA;
					PH_GREEN:     lamps.led_word = LED_TWO_GREEN;
					default:      lamps.led_word = LED_TWO_AMBER;
				endcase
			end
			PH_RED_AMBER: lamps.led_word = LED_ONE_RA;
			PH_GREEN:     lamps.led_word = LED_ONE_GREEN;
			default:      lamps.led_word = LED_ONE_AMBER;
		endcase
	end

endmodule

[rtl/core/two_road_traffic_light_controller.sv]
// Two-road traffic light controller with a pedestrian crossing.
// Input stream s_axis: one transaction per timer tick, tdata[0] is the walk button level.
// Output stream m_axis: one transaction per tick with both road phases, the six road lamp
// colours, the pedestrian lamp colour, the board LED word and the display digit, all as
// they stand after that tick.
// Config channel cfg: index 0 display switch ticks, 1 phase ticks, 2 walk ticks; writes
// are always taken and belong in idle periods. Other indexes are dropped.
// Throughput: one tick per cycle. The tick is held in an input register, and the counter
// and phase update with the lamp decode run in one step into the output register.
// When the receiver stalls, the output register holds its result, the input register
// fills, and s_axis_tready drops until the output drains.
// Reset: both roads red, pedestrian lamp red, digit 2, counters zero, registers at their
// defaults (250, 500, 1250); road one runs first.
`include "two_road_traffic_light_controller_macros.svh"

module two_road_traffic_light_controller #(
	parameter int TICK_COUNT_WIDTH = trlc_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [7:0]                            s_axis_tdata,  // walk_button, zero pad
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// road_one_phase, road_two_phase, road_one_top/middle/bottom_colour,
	// road_two_top/middle/bottom_colour, walk_colour, led_word, display_digit, zero pad
	output logic [111:0]                          m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [trlc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [trlc_pkg::CFG_WIDTH-1:0]        cfg_data
);
	import trlc_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;

	logic [CFG_WIDTH-1:0] disp_ticks_q, phase_ticks_q, walk_ticks_q;

	logic s1_valid_q, s1_button_q;
	logic advance;

	logic [TW-1:0]        tick_q, tick_d, tick_inc;
	logic [CFG_WIDTH-1:0] walk_cnt_q, walk_cnt_d, walk_inc;
	logic                 pend_q, pend_d;
	logic                 r1_fin_q, r1_fin_d, r2_fin_q, r2_fin_d;
	phase_t               ph1_q, ph1_d, ph2_q, ph2_d;
	logic                 walk_green_q, walk_green_d;
	logic [DIGIT_WIDTH-1:0] digit_q, digit_d;
	logic                 served;
	logic [TW-1:0]        disp_thr, phase_thr;

	lamps_t lamps;
	logic   out_valid_q;
	logic [105:0] out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_ticks_q  <= DISPLAY_SWITCH_RST;
			phase_ticks_q <= PHASE_TICKS_RST;
			walk_ticks_q  <= WALK_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DISPLAY_SWITCH: disp_ticks_q  <= cfg_data;
				CFG_PHASE:          phase_ticks_q <= cfg_data;
				CFG_WALK:           walk_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_button_q <= s_axis_tdata[0];
		end
	end

	assign disp_thr  = TW'(disp_ticks_q);
	assign phase_thr = TW'(phase_ticks_q);
	assign tick_inc  = tick_q + TW'(1);
	assign walk_inc  = walk_cnt_q + CFG_WIDTH'(1);
	assign served    = (s1_button_q || pend_q) && r1_fin_q;

	always_comb begin
		tick_d       = tick_q;
		walk_cnt_d   = walk_cnt_q;
		pend_d       = s1_button_q || pend_q;
		r1_fin_d     = r1_fin_q;
		r2_fin_d     = r2_fin_q;
		ph1_d        = ph1_q;
		ph2_d        = ph2_q;
		walk_green_d = walk_green_q;
		digit_d      = digit_q;
		if (served) begin
			if (walk_inc == walk_ticks_q) begin
				pend_d       = 1'b0;
				walk_green_d = 1'b0;
				walk_cnt_d   = '0;
			end else begin
				walk_green_d = 1'b1;
				walk_cnt_d   = walk_inc;
			end
		end else begin
			tick_d = tick_inc;
			if (tick_inc == disp_thr) begin
				digit_d = DIGIT_ONE;
			end
			if (tick_inc == phase_thr) begin
				digit_d = DIGIT_TWO;
				tick_d  = '0;
				if (r2_fin_q) begin
					ph1_d    = phase_t'(ph1_q + 2'd1);
					r1_fin_d = (ph1_d == PH_RED);
					r2_fin_d = (ph1_d != PH_RED);
				end else if (r1_fin_q) begin
					ph2_d    = phase_t'(ph2_q + 2'd1);
					r2_fin_d = (ph2_d == PH_RED);
					r1_fin_d = (ph2_d != PH_RED);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			walk_cnt_q   <= '0;
			pend_q       <= 1'b0;
			r1_fin_q     <= 1'b0;
			r2_fin_q     <= 1'b1;
			ph1_q        <= PH_RED;
			ph2_q        <= PH_RED;
			walk_green_q <= 1'b0;
			digit_q      <= DIGIT_TWO;
		end else if (advance) begin
			tick_q       <= tick_d;
			walk_cnt_q   <= walk_cnt_d;
			pend_q       <= pend_d;
			r1_fin_q     <= r1_fin_d;
			r2_fin_q     <= r2_fin_d;
			ph1_q        <= ph1_d;
			ph2_q        <= ph2_d;
			walk_green_q <= walk_green_d;
			digit_q      <= digit_d;
		end
	end

	trlc_lamp_decode u_decode (
		.phase_one (ph1_d),
		.phase_two (ph2_d),
		.lamps     (lamps)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {digit_d, lamps.led_word,
				walk_green_d ? LAMP_GREEN : LAMP_RED,
				lamps.two_bottom, lamps.two_middle, lamps.two_top,
				lamps.one_bottom, lamps.one_middle, lamps.one_top,
				ph2_d, ph1_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_data_q};

	`TRLC_ASSERT_NEVER(a_fin_complement, r1_fin_q == r2_fin_q, "finished flags not complementary")
	`TRLC_ASSERT(a_green_pending, walk_green_q |-> pend_q, "walk lamp green without request")
	`TRLC_ASSERT(a_count_pending, (walk_cnt_q != '0) |-> pend_q, "walk count without request")
	`TRLC_ASSERT(a_digit_code, digit_q == DIGIT_ONE || digit_q == DIGIT_TWO, "bad digit")
	`TRLC_ASSERT(a_advance_out, advance |=> m_axis_tvalid, "advanced tick produced no result")

endmodule
